>>> hdl/fdec_pkg.sv
// Shared types and constants of the block FIR decimator.
// Coefficient table, MAC control record and sequencer states.
// No dependencies; used by the core and the MAC unit of the block.
`default_nettype none

package fdec_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = 32;
    localparam int ACC_W       = 40;
    localparam int ROUND_SHIFT = 15;
    localparam int ROUND_BIAS  = 16384;
    localparam int SAT_MAX     = 32767;
    localparam int SAT_MIN     = -32768;
    localparam int MAC_LAT     = 2;

    localparam int RATIO_W     = 3;
    localparam int LEN_W       = 11;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 3'd4;
    localparam logic [LEN_W-1:0]   LEN_RESET   = 11'd768;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_DECIM_RATIO = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_LEN   = 2'd1;

    // Symmetric low-pass taps in Q1.15.
    localparam int COEF_N = 8;
    localparam logic signed [COEF_W-1:0] COEF_Q15 [COEF_N] = '{
        16'sd117, 16'sd1248, 16'sd5277, 16'sd9743,
        16'sd9743, 16'sd5277, 16'sd1248, 16'sd117
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                     clear;
        logic                     issue;
        logic signed [COEF_W-1:0] coef;
    } t_mac_ctl;

    // Taps past the end of the table have a zero coefficient.
    function automatic logic signed [COEF_W-1:0] tap_coef(input logic [31:0] j);
        if (j < 32'(COEF_N)) begin
            return COEF_Q15[j[2:0]];
        end else begin
            return '0;
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/block_fir_decimator_core.sv
// Block FIR decimator: input samples are grouped into blocks, filtered by a
// symmetric FIR and decimated. The channels are stream buses:
//   s_axis: one 16-bit signed sample per request.
//   m_axis: filtered sample in tdata, tlast marks the final result caused by
//           an input sample, tuser marks the final output of a block.
// Configuration: decimation ratio (index 0) and block length (index 1) via a
// plain write port; writing either restarts the current block. Write only while idle.
// Operation: an accepted sample is written into the tap memory, then every
// output that the sample completes is computed by one multiply-accumulate
// stepping through the tap memory, one read per cycle. An input that
// completes no output passes through one check; each output it completes
// adds the tap reads, the MAC pipeline drain, one emit, which waits while
// the receiver stalls, and one check. The final sample of a block can
// complete up to TAPS outputs at once.
// The result sits in an output register; the next sample is accepted while it
// waits. If the receiver stalls, the sequencer holds before overwriting it.
// Reset sets the ratio to 4, the block length to 768 and starts a new block.
// The tap memory needs no clearing: only samples of the current block are read.
`default_nettype none

module block_fir_decimator_core #(
    parameter int TAPS      = 8,
    parameter int MAX_BLOCK = 1024,
    parameter int MAX_RATIO = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [fdec_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [fdec_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input samples
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [15:0]                       i_s_axis_tdata,  // [15:0] sample
    // results
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [15:0]                            o_m_axis_tdata,  // [15:0] filtered
    output logic                                   o_m_axis_tlast,
    output logic                                   o_m_axis_tuser   // [0] last_of_block
);

    localparam int TW  = $clog2(TAPS);
    localparam int PW  = $clog2(MAX_BLOCK);
    localparam int BW  = $clog2(MAX_BLOCK + 2 * MAX_RATIO + TAPS + 1);
    localparam int NW  = $clog2(TAPS + 1);
    localparam int DRW = (fdec_pkg::MAC_LAT > 1) ? $clog2(fdec_pkg::MAC_LAT) : 1;

    fdec_pkg::t_state r_state, n_state;

    logic [fdec_pkg::RATIO_W-1:0] r_cfg_ratio;
    logic [fdec_pkg::LEN_W-1:0]   r_cfg_len;
    logic [PW-1:0]                r_in_pos;
    logic [TW-1:0]                r_wp;
    logic [BW-1:0]                r_base;
    logic [NW-1:0]                r_n;
    logic [TW-1:0]                r_j;
    logic [DRW-1:0]               r_drain;
    logic                         r_last;

    logic                         r_o_valid;
    logic [15:0]                  r_o_data;
    logic                         r_o_last;
    logic                         r_o_user;

    logic [BW-1:0] ratio_b, len_b, p_b, base_nx, tap_k, tap_d_full;
    logic [TW-1:0] tap_d, rd_addr;
    logic          s_accept, out_free, emit_ok, nx_emit, blk_end, tap_use;
    logic          ram_we, load_out, finish;
    logic [15:0]   ram_rdata;
    logic [15:0]   mac_result;
    fdec_pkg::t_mac_ctl mac_ctl;

    // Effective configuration: zero acts as one, large values are clamped.
    always_comb begin
        if (r_cfg_ratio == '0) begin
            ratio_b = BW'(1);
        end else if (32'(r_cfg_ratio) > 32'(MAX_RATIO)) begin
            ratio_b = BW'(MAX_RATIO);
        end else begin
            ratio_b = BW'(r_cfg_ratio);
        end
        if (r_cfg_len == '0) begin
            len_b = BW'(1);
        end else if (32'(r_cfg_len) > 32'(MAX_BLOCK)) begin
            len_b = BW'(MAX_BLOCK);
        end else begin
            len_b = BW'(r_cfg_len);
        end
    end

    assign p_b      = BW'(r_in_pos);
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_o_valid || i_m_axis_tready;

    // An output is due once all its taps are in, or at the end of the block.
    assign emit_ok = (r_base + ratio_b <= len_b)
                  && (r_last || (r_base + BW'(TAPS - 1) <= p_b))
                  && (r_n < NW'(TAPS));
    assign base_nx = r_base + ratio_b;
    assign nx_emit = (base_nx + ratio_b <= len_b)
                  && (r_last || (base_nx + BW'(TAPS - 1) <= p_b))
                  && (r_n + NW'(1) < NW'(TAPS));
    assign blk_end = (base_nx + ratio_b > len_b);

    // Tap j of the current output reads the sample at block position base + j,
    // which lies (p - k) slots behind the newest entry of the circular memory.
    assign tap_k      = r_base + BW'(r_j);
    assign tap_d_full = p_b - tap_k;
    assign tap_use    = (tap_k <= p_b) && (tap_d_full < BW'(TAPS));
    assign tap_d      = tap_d_full[TW-1:0];

    always_comb begin
        if (r_wp >= tap_d) begin
            rd_addr = r_wp - tap_d;
        end else begin
            rd_addr = TW'((TW + 1)'(r_wp) + (TW + 1)'(TAPS) - (TW + 1)'(tap_d));
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fdec_pkg::S_IDLE: begin
                if (s_accept) n_state = fdec_pkg::S_CHECK;
            end
            fdec_pkg::S_CHECK: begin
                n_state = emit_ok ? fdec_pkg::S_READ : fdec_pkg::S_IDLE;
            end
            fdec_pkg::S_READ: begin
                if (r_j == TW'(TAPS - 1)) n_state = fdec_pkg::S_DRAIN;
            end
            fdec_pkg::S_DRAIN: begin
                if (r_drain == DRW'(fdec_pkg::MAC_LAT - 1)) n_state = fdec_pkg::S_EMIT;
            end
            fdec_pkg::S_EMIT: begin
                if (out_free) n_state = fdec_pkg::S_CHECK;
            end
            default: n_state = fdec_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        ram_we          = 1'b0;
        mac_ctl.clear   = 1'b0;
        mac_ctl.issue   = 1'b0;
        mac_ctl.coef    = fdec_pkg::tap_coef(32'(r_j));
        load_out        = 1'b0;
        finish          = 1'b0;
        unique case (r_state)
            fdec_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                ram_we          = i_s_axis_tvalid;
            end
            fdec_pkg::S_CHECK: begin
                mac_ctl.clear = emit_ok;
                finish        = !emit_ok;
            end
            fdec_pkg::S_READ: begin
                mac_ctl.issue = tap_use;
            end
            fdec_pkg::S_DRAIN: begin
            end
            fdec_pkg::S_EMIT: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fdec_pkg::S_IDLE;
            r_cfg_ratio <= fdec_pkg::RATIO_RESET;
            r_cfg_len   <= fdec_pkg::LEN_RESET;
            r_in_pos    <= '0;
            r_wp        <= '0;
            r_base      <= '0;
            r_n         <= '0;
            r_j         <= '0;
            r_drain     <= '0;
            r_last      <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    fdec_pkg::REG_DECIM_RATIO: begin
                        r_cfg_ratio <= i_cfg_wdata[fdec_pkg::RATIO_W-1:0];
                        r_in_pos    <= '0;
                        r_wp        <= '0;
                        r_base      <= '0;
                    end
                    fdec_pkg::REG_BLOCK_LEN: begin
                        r_cfg_len <= i_cfg_wdata[fdec_pkg::LEN_W-1:0];
                        r_in_pos  <= '0;
                        r_wp      <= '0;
                        r_base    <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            if (s_accept) begin
                r_last <= (p_b + BW'(1) >= len_b);
                r_n    <= '0;
            end

            if (mac_ctl.clear) begin
                r_j <= '0;
            end else if (r_state == fdec_pkg::S_READ) begin
                r_j <= r_j + TW'(1);
            end

            if (r_state == fdec_pkg::S_DRAIN) begin
                r_drain <= r_drain + DRW'(1);
            end else begin
                r_drain <= '0;
            end

            if (load_out) begin
                r_base <= base_nx;
                r_n    <= r_n + NW'(1);
            end

            if (finish) begin
                if (r_last) begin
                    r_in_pos <= '0;
                    r_wp     <= '0;
                    r_base   <= '0;
                end else begin
                    r_in_pos <= r_in_pos + PW'(1);
                    r_wp     <= (r_wp == TW'(TAPS - 1)) ? '0 : r_wp + TW'(1);
                end
            end

            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_data <= mac_result;
            r_o_last <= !nx_emit;
            r_o_user <= blk_end;
        end
    end

    fdec_ram #(
        .WIDTH (fdec_pkg::SAMPLE_W),
        .DEPTH (TAPS)
    ) u_taps (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    fdec_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_sample (ram_rdata),
        .o_result (mac_result)
    );

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tuser  = r_o_user;

    // The position inside the block never reaches the block length.
    a_pos_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_b < len_b)
        else $error("input position outside the block");

    // Outputs of a block never pass the block end.
    a_base_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base <= len_b)
        else $error("output base past the block end");

    // No input causes more results than there are taps.
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(TAPS))
        else $error("too many results for one input");

    // A result waiting in the output register is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fdec_pkg::S_EMIT && r_o_valid && !i_m_axis_tready)
        |=> (r_state == fdec_pkg::S_EMIT && r_o_valid))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> hdl/fdec_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module fdec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/fdec_mac.sv
// Shared multiply-accumulate unit with rounding and saturation.
// Depends on fdec_pkg for widths, constants and the control record.
`default_nettype none

module fdec_mac (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire fdec_pkg::t_mac_ctl                      i_ctl,
    input  wire logic signed [fdec_pkg::SAMPLE_W-1:0]    i_sample,
    output logic signed      [fdec_pkg::SAMPLE_W-1:0]    o_result
);

    localparam int AW = fdec_pkg::ACC_W;
    localparam logic signed [AW-1:0] SAT_HI = AW'(fdec_pkg::SAT_MAX);
    localparam logic signed [AW-1:0] SAT_LO = AW'(fdec_pkg::SAT_MIN);

    logic                                   r_a_use;
    logic signed [fdec_pkg::COEF_W-1:0]     r_a_coef;
    logic signed [fdec_pkg::PROD_W-1:0]     r_b_prod;
    logic signed [AW-1:0]                   r_acc;
    logic signed [fdec_pkg::PROD_W-1:0]     prod;
    logic signed [AW-1:0]                   rounded;
    logic signed [AW-1:0]                   shifted;

    // The read data of the tap memory lines up with the delayed control.
    assign prod = i_sample * r_a_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_use  <= 1'b0;
            r_b_prod <= '0;
            r_acc    <= '0;
        end else begin
            r_a_use  <= i_ctl.issue;
            r_b_prod <= r_a_use ? prod : '0;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else begin
                r_acc <= r_acc + AW'(r_b_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_coef <= i_ctl.coef;
    end

    // Round half toward plus infinity, then clamp to the sample range.
    assign rounded = r_acc + AW'(fdec_pkg::ROUND_BIAS);
    assign shifted = rounded >>> fdec_pkg::ROUND_SHIFT;

    always_comb begin
        if (shifted > SAT_HI) begin
            o_result = fdec_pkg::SAMPLE_W'(fdec_pkg::SAT_MAX);
        end else if (shifted < SAT_LO) begin
            o_result = fdec_pkg::SAMPLE_W'(fdec_pkg::SAT_MIN);
        end else begin
            o_result = shifted[fdec_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire
